// ----- rtl/gcsa_pkg.sv -----
`default_nettype none

package gcsa_pkg;

    // configuration register indexes
    localparam logic [7:0] REG_STAT_ENABLE = 8'd0;
    localparam logic [7:0] REG_NODATA      = 8'd1;

    // stat_enable bit positions
    localparam int EN_COUNT  = 0;
    localparam int EN_MIN    = 1;
    localparam int EN_MAX    = 2;
    localparam int EN_MEAN   = 3;
    localparam int EN_IDW    = 4;
    localparam int EN_STDDEV = 5;

    localparam logic [5:0]  STAT_ENABLE_RST = 6'h3F;
    localparam logic [31:0] NODATA_RST      = 32'h0;

    // operation of the shared divide / root unit
    typedef enum logic {
        DR_DIV,
        DR_SQRT
    } dr_op_t;

    // request to the divide / root unit; dividend is left aligned so that
    // its significant bits are the top 'iters' bits (divide) or the whole
    // word (square root, two bits per iteration)
    typedef struct packed {
        dr_op_t       op;
        logic [6:0]   iters;
        logic [63:0]  dividend;
        logic [47:0]  divisor;
    } dr_req_t;

    // one grid cell record
    typedef struct packed {
        logic        [31:0] count;
        logic signed [31:0] min_v;
        logic signed [31:0] max_v;
        logic signed [39:0] mean;
        logic        [63:0] m2;
        logic signed [63:0] vsum;
        logic        [47:0] wsum;
        logic               exact;
    } cell_rec_t;

    localparam cell_rec_t CELL_RST = '{
        count: 32'd0,
        min_v: 32'sh7FFFFFFF,
        max_v: 32'sh80000000,
        mean:  40'sd0,
        m2:    64'd0,
        vsum:  64'sd0,
        wsum:  48'd0,
        exact: 1'b0
    };

endpackage

`default_nettype wire

// ----- rtl/gcsa_store.sv -----
`default_nettype none

module gcsa_store
    import gcsa_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire cell_rec_t     wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output cell_rec_t          rd_data
);

    cell_rec_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gcsa_divroot.sv -----
`default_nettype none

module gcsa_divroot
    import gcsa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire dr_req_t     req,
    output logic             done,
    output logic [63:0]      quot,
    output logic [31:0]      root
);

    logic        busy_reg;
    logic        done_reg;
    dr_op_t      op_reg;
    logic [6:0]  cnt_reg;
    logic [48:0] r_reg;
    logic [63:0] q_reg;
    logic [47:0] d_reg;

    logic [48:0] opa;
    logic [48:0] opb;
    logic [49:0] diff;
    logic        ge;

    // one shared subtract / compare for both recurrences
    always_comb begin
        if (op_reg == DR_DIV) begin
            opa = {r_reg[47:0], q_reg[63]};
            opb = {1'b0, d_reg};
        end else begin
            opa = {r_reg[46:0], q_reg[63:62]};
            opb = {15'd0, d_reg[31:0], 2'b01};
        end
        diff = {1'b0, opa} - {1'b0, opb};
        ge   = ~diff[49];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= req.iters;
                r_reg    <= '0;
                q_reg    <= req.dividend;
                d_reg    <= (req.op == DR_DIV) ? req.divisor : 48'd0;
            end else if (busy_reg) begin
                r_reg   <= ge ? diff[48:0] : opa;
                cnt_reg <= cnt_reg - 7'd1;
                if (op_reg == DR_DIV) begin
                    q_reg <= {q_reg[62:0], ge};
                end else begin
                    q_reg <= {q_reg[61:0], 2'b00};
                    d_reg <= {d_reg[46:0], ge};
                end
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign root = d_reg[31:0];

endmodule

`default_nettype wire

// ----- rtl/grid_cell_statistics_accumulator_core.sv -----
`default_nettype none

// Channel   Dir  Signals                          Item
// --------  ---  -------------------------------  ------------------------------
// s_        in   s_tvalid s_tready s_tdata s_tuser accumulate / read request
// m_        out  m_tvalid m_tready m_tdata         finished cell statistics
// cfg_      in   cfg_valid cfg_ready cfg_index     register write
//                cfg_data
//
// Items: one at a time. How long an accumulate or a read takes is set by
// the shared bit-serial divide / root unit (41 steps for the mean, 33 for
// the weight; 64 for the variance, 32 for the root, 64 for the IDW
// quotient). An accumulate outside the grid is dropped without a fetch.
// Reset: after aresetn the store is swept to its reset record, one cell a
// cycle, with s_tready low; config is taken.
// Stalls: a finished result waits in the output register while the next
// item is accepted; the sequencer only holds when a second result is ready.

module grid_cell_statistics_accumulator_core
    import gcsa_pkg::*;
#(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // fields from bit 0: col[7:0], row[15:8], sample_value[47:16],
    // sample_distance[79:48]
    input  wire logic [79:0]  s_tdata,
    // fields from bit 0: kind[0]
    input  wire logic [0:0]   s_tuser,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // fields from bit 0: sample_count[31:0], cell_empty[32], min_out[64:33],
    // max_out[96:65], mean_out[128:97], idw_out[160:129],
    // stddev_out[192:161], zero fill[199:193]
    output logic [199:0]      m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    localparam int CELLS   = GRID_COLS * GRID_ROWS;
    localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam logic [6:0] IT_MEAN   = 7'd41;
    localparam logic [6:0] IT_WEIGHT = 7'd33;
    localparam logic [6:0] IT_WIDE   = 7'd64;
    localparam logic [6:0] IT_ROOT   = 7'd32;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_PREP,
        ST_MEAN_W,
        ST_MUL,
        ST_M2,
        ST_W_W,
        ST_VMUL,
        ST_VADD,
        ST_WRITE,
        ST_RPREP,
        ST_VAR_W,
        ST_SQRT_W,
        ST_IDW_W,
        ST_OUT
    } state_t;

    state_t                state_reg;
    logic [CELL_AW-1:0]    clr_addr_reg;
    logic                  kind_reg;
    logic                  inside_reg;
    logic [CELL_AW-1:0]    addr_reg;
    logic signed [31:0]    v_reg;
    logic [31:0]           dist_reg;
    cell_rec_t             rec_reg;
    logic signed [40:0]    delta_reg;
    logic [40:0]           ma_reg;
    logic [40:0]           mb_reg;
    logic [81:0]           acc_reg;
    logic [2:0]            mul_k_reg;
    logic [63:0]           mul_p_reg;
    logic [32:0]           w_reg;
    logic [31:0]           cnt_reg;
    logic [31:0]           sd_reg;
    logic [31:0]           idw_reg;
    logic [199:0]          m_tdata_reg;
    logic                  m_valid_reg;
    logic [5:0]            en_reg;
    logic [31:0]           nodata_reg;

    // input item unpack
    logic                  in_kind;
    logic [7:0]            in_col;
    logic [7:0]            in_row;
    logic [31:0]           in_lin;
    logic                  in_inside;
    logic [CELL_AW-1:0]    in_addr;
    logic                  s_accept;

    assign in_kind   = s_tuser[0];
    assign in_col    = s_tdata[7:0];
    assign in_row    = s_tdata[15:8];
    assign in_lin    = 32'(in_row) * 32'(GRID_COLS) + 32'(in_col);
    assign in_inside = (32'(in_col) < 32'(GRID_COLS)) && (32'(in_row) < 32'(GRID_ROWS));
    assign in_addr   = in_inside ? in_lin[CELL_AW-1:0] : '0;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // cell store
    logic               wr_en;
    logic [CELL_AW-1:0] wr_addr;
    cell_rec_t          wr_data;
    cell_rec_t          rd_data;

    assign wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? CELL_RST : rec_reg;

    gcsa_store #(
        .DEPTH (CELLS),
        .AW    (CELL_AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s_accept),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    // shared divide / root unit
    logic        dr_start;
    dr_req_t     dr_req;
    logic        dr_done;
    logic [63:0] dr_quot;
    logic [31:0] dr_root;

    gcsa_divroot u_divroot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dr_start),
        .req     (dr_req),
        .done    (dr_done),
        .quot    (dr_quot),
        .root    (dr_root)
    );

    // accumulate datapath
    logic signed [39:0] v16;
    logic [31:0]        count_next;
    logic signed [40:0] mean_ext;
    logic signed [40:0] delta_c;
    logic [40:0]        delta_mag;
    logic signed [40:0] q_signed;
    logic signed [40:0] mean_new;
    logic signed [40:0] e2_c;
    logic [40:0]        e2_mag;
    logic [31:0]        vmag;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [81:0]        acc_add;
    logic [63:0]        term;
    logic [64:0]        m2_sum;
    logic [63:0]        vprod;
    logic signed [65:0] vsum_ext;
    logic signed [65:0] vsum_acc;
    logic [63:0]        vsum_next;
    logic [48:0]        wsum_sum;

    // read datapath
    logic [31:0]        rcnt;
    logic [63:0]        vsum_mag;
    logic [31:0]        exact_out;
    logic               q_big;
    logic [31:0]        idw_div_out;
    logic               empty;

    always_comb begin
        v16        = {v_reg, 8'd0};
        count_next = (rec_reg.count == 32'hFFFFFFFF) ? rec_reg.count : rec_reg.count + 32'd1;
        mean_ext   = {rec_reg.mean[39], rec_reg.mean};
        delta_c    = $signed({v16[39], v16}) - mean_ext;
        delta_mag  = delta_c[40] ? 41'(-delta_c) : 41'(delta_c);

        // mean step: quotient carries the sign of delta, truncated toward zero
        q_signed = delta_reg[40] ? -$signed({1'b0, dr_quot[39:0]})
                                 :  $signed({1'b0, dr_quot[39:0]});
        mean_new = mean_ext + q_signed;
        e2_c     = $signed({v16[39], v16}) - mean_new;
        e2_mag   = e2_c[40] ? 41'(-e2_c) : 41'(e2_c);

        vmag = v_reg[31] ? (~32'(v_reg) + 32'd1) : 32'(v_reg);

        // 41 x 41 product as four partial products on one 32 x 32 multiplier
        mul_a = 32'd0;
        mul_b = 32'd0;
        if (state_reg == ST_VMUL) begin
            mul_a = vmag;
            mul_b = w_reg[31:0];
        end else begin
            case (mul_k_reg)
                3'd0: begin
                    mul_a = ma_reg[31:0];
                    mul_b = mb_reg[31:0];
                end
                3'd1: begin
                    mul_a = ma_reg[31:0];
                    mul_b = 32'(mb_reg[40:32]);
                end
                3'd2: begin
                    mul_a = 32'(ma_reg[40:32]);
                    mul_b = mb_reg[31:0];
                end
                3'd3: begin
                    mul_a = 32'(ma_reg[40:32]);
                    mul_b = 32'(mb_reg[40:32]);
                end
                default: begin
                    mul_a = 32'd0;
                    mul_b = 32'd0;
                end
            endcase
        end

        // add the product issued on the previous step at its weight
        case (mul_k_reg) inside
            3'd1:       acc_add = 82'(mul_p_reg);
            3'd2, 3'd3: acc_add = 82'(mul_p_reg) << 32;
            3'd4:       acc_add = 82'(mul_p_reg) << 64;
            default:    acc_add = 82'd0;
        endcase

        term   = (acc_reg[81:80] != 2'b00) ? 64'hFFFFFFFFFFFFFFFF : acc_reg[79:16];
        m2_sum = {1'b0, rec_reg.m2} + {1'b0, term};

        // weight 2^32 (distance one ulp) has a zero low word
        vprod    = w_reg[32] ? {vmag, 32'd0} : mul_p_reg;
        vsum_ext = {{2{rec_reg.vsum[63]}}, rec_reg.vsum};
        vsum_acc = v_reg[31] ? vsum_ext - $signed({2'b00, vprod})
                             : vsum_ext + $signed({2'b00, vprod});
        if ((vsum_acc[65:63] == 3'b000) || (vsum_acc[65:63] == 3'b111)) begin
            vsum_next = vsum_acc[63:0];
        end else if (vsum_acc[65]) begin
            vsum_next = 64'h8000000000000000;
        end else begin
            vsum_next = 64'h7FFFFFFFFFFFFFFF;
        end
        wsum_sum = {1'b0, rec_reg.wsum} + 49'(w_reg);

        rcnt     = inside_reg ? rec_reg.count : 32'd0;
        vsum_mag = rec_reg.vsum[63] ? (~64'(rec_reg.vsum) + 64'd1) : 64'(rec_reg.vsum);

        if ((rec_reg.vsum[63:31] == '0) || (rec_reg.vsum[63:31] == '1)) begin
            exact_out = rec_reg.vsum[31:0];
        end else if (rec_reg.vsum[63]) begin
            exact_out = 32'h80000000;
        end else begin
            exact_out = 32'h7FFFFFFF;
        end

        q_big = (dr_quot[63:31] != '0);
        if (rec_reg.vsum[63]) begin
            idw_div_out = q_big ? 32'h80000000 : (~dr_quot[31:0] + 32'd1);
        end else begin
            idw_div_out = q_big ? 32'h7FFFFFFF : dr_quot[31:0];
        end

        empty = (cnt_reg == 32'd0);
    end

    // divide / root requests by sequencer step
    always_comb begin
        dr_start = 1'b0;
        dr_req   = '{op: DR_DIV, iters: IT_WIDE, dividend: 64'd0, divisor: 48'd0};
        unique case (state_reg)
            ST_PREP: begin
                dr_start = 1'b1;
                dr_req   = '{op: DR_DIV, iters: IT_MEAN,
                             dividend: 64'(delta_mag) << 23, divisor: 48'(count_next)};
            end
            ST_M2: begin
                dr_start = !rec_reg.exact && (dist_reg != 32'd0);
                dr_req   = '{op: DR_DIV, iters: IT_WEIGHT,
                             dividend: 64'h8000000000000000, divisor: 48'(dist_reg)};
            end
            ST_RPREP: begin
                dr_start = (rcnt != 32'd0);
                dr_req   = '{op: DR_DIV, iters: IT_WIDE,
                             dividend: rec_reg.m2, divisor: 48'(rcnt)};
            end
            ST_VAR_W: begin
                dr_start = dr_done;
                dr_req   = '{op: DR_SQRT, iters: IT_ROOT,
                             dividend: dr_quot, divisor: 48'd0};
            end
            ST_SQRT_W: begin
                dr_start = dr_done && !rec_reg.exact && (rec_reg.wsum != 48'd0);
                dr_req   = '{op: DR_DIV, iters: IT_WIDE,
                             dividend: vsum_mag, divisor: rec_reg.wsum};
            end
            default: begin
                dr_start = 1'b0;
            end
        endcase
    end

    // sequencer, item registers and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
            en_reg       <= STAT_ENABLE_RST;
            nodata_reg   <= NODATA_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_STAT_ENABLE: en_reg     <= cfg_data[5:0];
                    REG_NODATA:      nodata_reg <= cfg_data;
                    default:         ;
                endcase
            end

            // the output step reloads the register itself
            if (m_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            mul_p_reg <= 64'(mul_a) * 64'(mul_b);

            unique case (state_reg)
                ST_CLEAR: begin
                    if (32'(clr_addr_reg) == 32'(CELLS - 1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        kind_reg   <= in_kind;
                        inside_reg <= in_inside;
                        addr_reg   <= in_addr;
                        v_reg      <= $signed(s_tdata[47:16]);
                        dist_reg   <= s_tdata[79:48];
                        // an accumulate outside the grid is dropped
                        state_reg  <= (!in_kind && !in_inside) ? ST_IDLE : ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    rec_reg   <= rd_data;
                    state_reg <= kind_reg ? ST_RPREP : ST_PREP;
                end
                ST_PREP: begin
                    rec_reg.count <= count_next;
                    if (v_reg < rec_reg.min_v) rec_reg.min_v <= v_reg;
                    if (v_reg > rec_reg.max_v) rec_reg.max_v <= v_reg;
                    delta_reg <= delta_c;
                    state_reg <= ST_MEAN_W;
                end
                ST_MEAN_W: begin
                    if (dr_done) begin
                        rec_reg.mean <= mean_new[39:0];
                        ma_reg       <= 41'(delta_reg[40] ? -delta_reg : delta_reg);
                        mb_reg       <= e2_mag;
                        acc_reg      <= '0;
                        mul_k_reg    <= 3'd0;
                        state_reg    <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    acc_reg   <= acc_reg + acc_add;
                    mul_k_reg <= mul_k_reg + 3'd1;
                    if (mul_k_reg == 3'd4) begin
                        state_reg <= ST_M2;
                    end
                end
                ST_M2: begin
                    rec_reg.m2 <= m2_sum[64] ? 64'hFFFFFFFFFFFFFFFF : m2_sum[63:0];
                    if (rec_reg.exact) begin
                        state_reg <= ST_WRITE;
                    end else if (dist_reg == 32'd0) begin
                        // zero distance latches the exact value
                        rec_reg.vsum  <= 64'(v_reg);
                        rec_reg.exact <= 1'b1;
                        state_reg     <= ST_WRITE;
                    end else begin
                        state_reg <= ST_W_W;
                    end
                end
                ST_W_W: begin
                    if (dr_done) begin
                        w_reg     <= dr_quot[32:0];
                        state_reg <= ST_VMUL;
                    end
                end
                ST_VMUL: begin
                    state_reg <= ST_VADD;
                end
                ST_VADD: begin
                    rec_reg.vsum <= vsum_next;
                    rec_reg.wsum <= wsum_sum[48] ? 48'hFFFFFFFFFFFF : wsum_sum[47:0];
                    state_reg    <= ST_WRITE;
                end
                ST_WRITE: begin
                    state_reg <= ST_IDLE;
                end
                ST_RPREP: begin
                    cnt_reg   <= rcnt;
                    state_reg <= (rcnt == 32'd0) ? ST_OUT : ST_VAR_W;
                end
                ST_VAR_W: begin
                    if (dr_done) begin
                        state_reg <= ST_SQRT_W;
                    end
                end
                ST_SQRT_W: begin
                    if (dr_done) begin
                        sd_reg <= dr_root[31] ? 32'h7FFFFFFF : dr_root;
                        if (rec_reg.exact) begin
                            idw_reg   <= exact_out;
                            state_reg <= ST_OUT;
                        end else if (rec_reg.wsum == 48'd0) begin
                            idw_reg   <= 32'd0;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_IDW_W;
                        end
                    end
                end
                ST_IDW_W: begin
                    if (dr_done) begin
                        idw_reg   <= idw_div_out;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold only while the previous result is still unclaimed
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_tdata_reg[31:0]    <= en_reg[EN_COUNT] ? cnt_reg : 32'd0;
                        m_tdata_reg[32]      <= empty;
                        m_tdata_reg[64:33]   <= !en_reg[EN_MIN] ? 32'd0 :
                                                (empty ? nodata_reg : 32'(rec_reg.min_v));
                        m_tdata_reg[96:65]   <= !en_reg[EN_MAX] ? 32'd0 :
                                                (empty ? nodata_reg : 32'(rec_reg.max_v));
                        m_tdata_reg[128:97]  <= !en_reg[EN_MEAN] ? 32'd0 :
                                                (empty ? nodata_reg : rec_reg.mean[39:8]);
                        m_tdata_reg[160:129] <= !en_reg[EN_IDW] ? 32'd0 :
                                                (empty ? nodata_reg : idw_reg);
                        m_tdata_reg[192:161] <= !en_reg[EN_STDDEV] ? 32'd0 :
                                                (empty ? nodata_reg : sd_reg);
                        m_tdata_reg[199:193] <= 7'd0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire
